// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define AFPC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Check that cons holds in the cycle after ante
`define AFPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/afpc_pkg.sv =====
// Types and constants of the API frame parser
package afpc_pkg;

	localparam logic [7:0] DELIM = 8'h7E;
	localparam logic [7:0] TYPE_RX = 8'h90;
	localparam logic [7:0] TYPE_AT = 8'h88;
	localparam logic [7:0] SUM_INIT = 8'hFF;
	localparam logic [15:0] CMD_ND = 16'h4E44;
	localparam logic [15:0] RX_FIXED = 16'd13;
	localparam logic [15:0] AT_FIXED = 16'd5;
	localparam logic [15:0] SRC_BYTES = 16'd8;

	typedef enum logic [1:0] {
		EV_PAYLOAD = 2'd0,
		EV_RX_END  = 2'd1,
		EV_AT_END  = 2'd2
	} event_t;

	typedef enum logic [15:0] {
		PH_HUNT    = 16'h0001,
		PH_LEN_HI  = 16'h0002,
		PH_LEN_LO  = 16'h0004,
		PH_TYPE    = 16'h0008,
		PH_SRC     = 16'h0010,
		PH_NET_HI  = 16'h0020,
		PH_NET_LO  = 16'h0040,
		PH_OPT     = 16'h0080,
		PH_KIND    = 16'h0100,
		PH_PAYLOAD = 16'h0200,
		PH_FID     = 16'h0400,
		PH_CMD_HI  = 16'h0800,
		PH_CMD_LO  = 16'h1000,
		PH_STATUS  = 16'h2000,
		PH_DATA    = 16'h4000,
		PH_CHECK   = 16'h8000
	} phase_t;

	typedef struct packed {
		event_t      event_res;
		logic [7:0]  payload_byte;
		logic        checksum_ok;
		logic [7:0]  computed_checksum;
		logic [7:0]  data_kind;
		logic [15:0] source_network_address;
		logic [7:0]  rx_options;
		logic [15:0] at_command;
		logic [7:0]  command_status;
		logic [7:0]  frame_id;
		logic [15:0] node_address;
	} res_t;

endpackage

// ===== rtl/afpc_byte_if.sv =====
// Byte channel carrying received serial bytes
interface afpc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/afpc_res_if.sv =====
// Result channel carrying parser events
interface afpc_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  event_res;
	logic [7:0]  payload_byte;
	logic        checksum_ok;
	logic [7:0]  computed_checksum;
	logic [7:0]  data_kind;
	logic [15:0] source_network_address;
	logic [7:0]  rx_options;
	logic [15:0] at_command;
	logic [7:0]  command_status;
	logic [7:0]  frame_id;
	logic [15:0] node_address;

	modport source (
		output valid, output event_res, output payload_byte, output checksum_ok,
		output computed_checksum, output data_kind, output source_network_address,
		output rx_options, output at_command, output command_status, output frame_id,
		output node_address, input ready
	);
	modport sink (
		input valid, input event_res, input payload_byte, input checksum_ok,
		input computed_checksum, input data_kind, input source_network_address,
		input rx_options, input at_command, input command_status, input frame_id,
		input node_address, output ready
	);
endinterface

// ===== rtl/afpc_parser.sv =====
// Frame state machine and result generation for payload and checksum bytes
module afpc_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       rx_byte,
	output logic             push,
	output afpc_pkg::res_t   result
);

	afpc_pkg::phase_t phase_q, phase_d;
	logic [15:0] len_q, len_d;
	logic [15:0] left_q, left_d;
	logic [7:0]  kind_q, kind_d;
	logic [7:0]  sum_q, sum_d;
	logic [15:0] net_q, net_d;
	logic [7:0]  opt_q, opt_d;
	logic [7:0]  dkind_q, dkind_d;
	logic [7:0]  fid_q, fid_d;
	logic [15:0] cmd_q, cmd_d;
	logic [7:0]  status_q, status_d;
	logic [15:0] pair_q, pair_d;
	logic [15:0] node_q, node_d;
	logic [1:0]  didx_q, didx_d;
	logic [15:0] left_dec;
	logic [15:0] rx_var;
	logic [15:0] at_var;

	assign left_dec = left_q - 16'd1;
	assign rx_var = (len_q > afpc_pkg::RX_FIXED) ? len_q - afpc_pkg::RX_FIXED : 16'd0;
	assign at_var = (len_q > afpc_pkg::AT_FIXED) ? len_q - afpc_pkg::AT_FIXED : 16'd0;

	always_comb begin
		phase_d = phase_q;
		len_d = len_q;
		left_d = left_q;
		kind_d = kind_q;
		sum_d = sum_q - rx_byte;
		net_d = net_q;
		opt_d = opt_q;
		dkind_d = dkind_q;
		fid_d = fid_q;
		cmd_d = cmd_q;
		status_d = status_q;
		pair_d = pair_q;
		node_d = node_q;
		didx_d = didx_q;
		push = 1'b0;
		result = '0;
		result.node_address = node_q;
		case (phase_q)
			afpc_pkg::PH_HUNT: begin
				sum_d = sum_q;
				if (rx_byte == afpc_pkg::DELIM) begin
					phase_d = afpc_pkg::PH_LEN_HI;
				end
			end
			afpc_pkg::PH_LEN_HI: begin
				sum_d = sum_q;
				len_d = {rx_byte, 8'h00};
				phase_d = afpc_pkg::PH_LEN_LO;
			end
			afpc_pkg::PH_LEN_LO: begin
				sum_d = sum_q;
				len_d = {len_q[15:8], rx_byte};
				phase_d = afpc_pkg::PH_TYPE;
			end
			afpc_pkg::PH_TYPE: begin
				kind_d = rx_byte;
				sum_d = afpc_pkg::SUM_INIT - rx_byte;
				if (rx_byte == afpc_pkg::TYPE_RX) begin
					left_d = afpc_pkg::SRC_BYTES;
					phase_d = afpc_pkg::PH_SRC;
				end else if (rx_byte == afpc_pkg::TYPE_AT) begin
					pair_d = node_q;
					phase_d = afpc_pkg::PH_FID;
				end else begin
					phase_d = afpc_pkg::PH_HUNT;
				end
			end
			afpc_pkg::PH_SRC: begin
				left_d = left_dec;
				if (left_dec == 16'd0) begin
					phase_d = afpc_pkg::PH_NET_HI;
				end
			end
			afpc_pkg::PH_NET_HI: begin
				net_d = {rx_byte, 8'h00};
				phase_d = afpc_pkg::PH_NET_LO;
			end
			afpc_pkg::PH_NET_LO: begin
				net_d = {net_q[15:8], rx_byte};
				phase_d = afpc_pkg::PH_OPT;
			end
			afpc_pkg::PH_OPT: begin
				opt_d = rx_byte;
				phase_d = afpc_pkg::PH_KIND;
			end
			afpc_pkg::PH_KIND: begin
				dkind_d = rx_byte;
				left_d = rx_var;
				phase_d = (rx_var != 16'd0) ? afpc_pkg::PH_PAYLOAD : afpc_pkg::PH_CHECK;
			end
			afpc_pkg::PH_FID: begin
				fid_d = rx_byte;
				phase_d = afpc_pkg::PH_CMD_HI;
			end
			afpc_pkg::PH_CMD_HI: begin
				cmd_d = {rx_byte, 8'h00};
				phase_d = afpc_pkg::PH_CMD_LO;
			end
			afpc_pkg::PH_CMD_LO: begin
				cmd_d = {cmd_q[15:8], rx_byte};
				phase_d = afpc_pkg::PH_STATUS;
			end
			afpc_pkg::PH_STATUS: begin
				status_d = rx_byte;
				left_d = at_var;
				didx_d = 2'd0;
				phase_d = (at_var != 16'd0) ? afpc_pkg::PH_DATA : afpc_pkg::PH_CHECK;
			end
			afpc_pkg::PH_PAYLOAD, afpc_pkg::PH_DATA: begin
				if (phase_q == afpc_pkg::PH_DATA) begin
					if (didx_q == 2'd0) begin
						pair_d = {rx_byte, pair_q[7:0]};
					end else if (didx_q == 2'd1) begin
						pair_d = {pair_q[15:8], rx_byte};
					end
					if (didx_q != 2'd2) begin
						didx_d = didx_q + 2'd1;
					end
				end
				left_d = left_dec;
				if (left_dec == 16'd0) begin
					phase_d = afpc_pkg::PH_CHECK;
				end
				push = 1'b1;
				result.event_res = afpc_pkg::EV_PAYLOAD;
				result.payload_byte = rx_byte;
			end
			afpc_pkg::PH_CHECK: begin
				sum_d = sum_q;
				push = 1'b1;
				result.checksum_ok = (sum_q == rx_byte);
				result.computed_checksum = sum_q;
				if (kind_q == afpc_pkg::TYPE_RX) begin
					result.event_res = afpc_pkg::EV_RX_END;
					result.data_kind = dkind_q;
					result.source_network_address = net_q;
					result.rx_options = opt_q;
				end else begin
					if (cmd_q == afpc_pkg::CMD_ND) begin
						node_d = pair_q;
					end
					result.event_res = afpc_pkg::EV_AT_END;
					result.at_command = cmd_q;
					result.command_status = status_q;
					result.frame_id = fid_q;
					result.node_address = node_d;
				end
				phase_d = afpc_pkg::PH_HUNT;
			end
			default: begin
				sum_d = sum_q;
				phase_d = afpc_pkg::PH_HUNT;
			end
		endcase
		if (!accept) begin
			push = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= afpc_pkg::PH_HUNT;
			len_q <= '0;
			left_q <= '0;
			kind_q <= '0;
			sum_q <= afpc_pkg::SUM_INIT;
			net_q <= '0;
			opt_q <= '0;
			dkind_q <= '0;
			fid_q <= '0;
			cmd_q <= '0;
			status_q <= '0;
			pair_q <= '0;
			node_q <= '0;
			didx_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			len_q <= len_d;
			left_q <= left_d;
			kind_q <= kind_d;
			sum_q <= sum_d;
			net_q <= net_d;
			opt_q <= opt_d;
			dkind_q <= dkind_d;
			fid_q <= fid_d;
			cmd_q <= cmd_d;
			status_q <= status_d;
			pair_q <= pair_d;
			node_q <= node_d;
			didx_q <= didx_d;
		end
	end

endmodule

// ===== rtl/api_frame_parser_checksum_top.sv =====
// Top level of the API frame parser with checksum check
//
// channel  dir  payload
// rx       in   rx_byte, one received serial byte per beat
// evt      out  event_res and frame fields, at most one beat per rx beat
//
// One byte is taken per cycle while rx.ready is high; the frame state updates in the cycle of the beat.
// A result reaches evt through a two-entry output buffer: out_q, or skid_q first while out_q is held.
// rx stalls only when both output entries are full.
// arst_n returns the parser to delimiter hunting and empties the buffer.
`include "assert_macros.svh"

module api_frame_parser_checksum_top (
	input  logic            clk,
	input  logic            arst_n,
	afpc_byte_if.sink       rx,
	afpc_res_if.source      evt
);

	logic           accept;
	logic           push;
	afpc_pkg::res_t result;
	afpc_pkg::res_t out_q;
	afpc_pkg::res_t skid_q;
	logic           out_v_q;
	logic           skid_v_q;
	logic           out_free;

	assign rx.ready = !skid_v_q;
	assign accept = rx.valid && rx.ready;
	assign out_free = !out_v_q || evt.ready;

	afpc_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (rx.rx_byte),
		.push    (push),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			if (skid_v_q) begin
				out_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_v_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= result;
			end
		end else if (push) begin
			skid_q <= result;
		end
	end

	assign evt.valid = out_v_q;
	assign evt.event_res = out_q.event_res;
	assign evt.payload_byte = out_q.payload_byte;
	assign evt.checksum_ok = out_q.checksum_ok;
	assign evt.computed_checksum = out_q.computed_checksum;
	assign evt.data_kind = out_q.data_kind;
	assign evt.source_network_address = out_q.source_network_address;
	assign evt.rx_options = out_q.rx_options;
	assign evt.at_command = out_q.at_command;
	assign evt.command_status = out_q.command_status;
	assign evt.frame_id = out_q.frame_id;
	assign evt.node_address = out_q.node_address;

	`AFPC_ASSERT_SAME(a_skid_behind_out, clk, arst_n, skid_v_q, out_v_q)
	`AFPC_ASSERT_NEXT(a_push_lands, clk, arst_n, push, out_v_q)
	`AFPC_ASSERT_SAME(a_payload_clean, clk, arst_n, out_v_q && out_q.event_res == afpc_pkg::EV_PAYLOAD, out_q.computed_checksum == 8'h00 && out_q.at_command == 16'h0000)
	`AFPC_ASSERT_SAME(a_rx_end_clean, clk, arst_n, out_v_q && out_q.event_res == afpc_pkg::EV_RX_END, out_q.frame_id == 8'h00 && out_q.payload_byte == 8'h00)

endmodule
